/* rtl/htfc_pkg.sv */
// shared constants, stage types and checksum helper for the frame check and convert block
package htfc_pkg;

    // x^8+x^5+x^4+1 with the x^8 term implied
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [14:0] T_MUL       = 15'd17572;
    localparam logic [15:0] T_OFF       = 16'd4685;
    localparam logic [13:0] H_MUL       = 14'd12500;
    localparam logic [14:0] H_OFF       = 15'd600;
    localparam logic [6:0]  CENTI       = 7'd100;
    localparam logic [13:0] MICRO_SCALE = 14'd10000;
    // floor(n / 100) == (n * 5243) >> 19 for every n below 43690
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic FUNC_TEMP  = 1'b0;
    localparam logic FUNC_HUMID = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic        status;
        logic [15:0] temp_raw;
        logic [15:0] humid_raw;
    } raw_stage_t;

    typedef struct packed {
        logic               status;
        logic signed [15:0] temp_centi;
        logic signed [14:0] humid_centi;
    } centi_stage_t;

    typedef struct packed {
        logic        status;
        logic        temp_neg;
        logic [13:0] temp_mag;
        logic [7:0]  temp_q;
        logic        humid_neg;
        logic [13:0] humid_mag;
        logic [6:0]  humid_q;
    } quot_stage_t;

    typedef struct packed {
        logic       status;
        logic       temp_neg;
        logic [7:0] temp_q;
        logic [6:0] temp_rem;
        logic       humid_neg;
        logic [6:0] humid_q;
        logic [6:0] humid_rem;
    } rem_stage_t;

    // checksum contribution of message bit k alone (bit 15 is the first bit sent)
    function automatic logic [7:0] crc_column(input int k);
        logic [15:0] msg;
        logic [7:0]  c;
        logic        fb;
        msg = 16'd1 << k;
        c   = 8'd0;
        for (int j = 15; j >= 0; j--)
        begin
            fb = c[7] ^ msg[j];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'd0);
        end
        return c;
    endfunction

endpackage

/* rtl/humidity_temp_frame_check_convert.sv */
// top level: frame checksum, sample registers and conversion pipeline
// throughput: one word per cycle; each stage holds while the one after it is full and stalled
// the pipeline is input register, checksum/update, scale, divide by 100, remainder, output
// reset clears all stage valids and both stored samples to zero
// before any good frame the outputs read -46.850000 degrees and -6.000000 percent
module humidity_temp_frame_check_convert
    import htfc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  logic [7:0]          sample_high,
    input  logic [7:0]          sample_low,
    input  logic [7:0]          check_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                status,
    output logic signed [8:0]   temp_whole,
    output logic signed [20:0]  temp_micro,
    output logic signed [7:0]   humid_whole,
    output logic signed [20:0]  humid_micro
);

    function automatic logic [13:0] times_100(input logic [7:0] q);
        return (14'(q) << 6) + (14'(q) << 5) + (14'(q) << 2);
    endfunction

    // stage valids
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, vout_reg;
    logic adv0, adv1, adv2, adv3, adv4, adv5;

    assign adv5     = !vout_reg || !out_stall;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign adv0     = !v0_reg || adv1;
    assign in_stall = !adv0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            if (adv0) v0_reg   <= in_valid;
            if (adv1) v1_reg   <= v0_reg;
            if (adv2) v2_reg   <= v1_reg;
            if (adv3) v3_reg   <= v2_reg;
            if (adv4) v4_reg   <= v3_reg;
            if (adv5) vout_reg <= v4_reg;
        end
    end

    // input register
    logic       func_reg;
    logic [7:0] high_reg, low_reg, check_reg;

    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            func_reg  <= func;
            high_reg  <= sample_high;
            low_reg   <= sample_low;
            check_reg <= check_byte;
        end
    end

    // checksum and sample update
    logic [7:0]  crc_val;
    logic        crc_ok;
    logic [15:0] temp_raw_reg, temp_raw_next;
    logic [15:0] humid_raw_reg, humid_raw_next;
    logic        take0;

    htfc_crc8 u_crc
    (
        .data ({high_reg, low_reg}),
        .crc  (crc_val)
    );

    assign crc_ok = (crc_val == check_reg);
    assign take0  = v0_reg && adv1;

    always_comb
    begin
        temp_raw_next  = temp_raw_reg;
        humid_raw_next = humid_raw_reg;
        if (crc_ok && func_reg == FUNC_TEMP)
        begin
            temp_raw_next = {high_reg, low_reg};
        end
        if (crc_ok && func_reg == FUNC_HUMID)
        begin
            humid_raw_next = {high_reg, low_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_raw_reg  <= 16'd0;
            humid_raw_reg <= 16'd0;
        end
        else if (take0)
        begin
            temp_raw_reg  <= temp_raw_next;
            humid_raw_reg <= humid_raw_next;
        end
    end

    raw_stage_t s1_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_reg.status    <= crc_ok ? STATUS_OK : STATUS_ERR;
            s1_reg.temp_raw  <= temp_raw_next;
            s1_reg.humid_raw <= humid_raw_next;
        end
    end

    // scale to centi-units
    logic [30:0]  temp_prod;
    logic [29:0]  humid_prod;
    centi_stage_t s2_reg;

    assign temp_prod  = 31'(s1_reg.temp_raw) * 31'(T_MUL);
    assign humid_prod = 30'(s1_reg.humid_raw) * 30'(H_MUL);

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_reg.status      <= s1_reg.status;
            s2_reg.temp_centi  <= $signed({1'b0, temp_prod[30:16]}) - $signed(T_OFF);
            s2_reg.humid_centi <= $signed({1'b0, humid_prod[29:16]}) - $signed(H_OFF);
        end
    end

    // magnitude and quotient by 100
    logic [13:0] temp_mag, humid_mag;
    logic [26:0] temp_qprod, humid_qprod;
    quot_stage_t s3_reg;

    assign temp_mag    = s2_reg.temp_centi[15] ? 14'(-s2_reg.temp_centi)
                                               : s2_reg.temp_centi[13:0];
    assign humid_mag   = s2_reg.humid_centi[14] ? 14'(-s2_reg.humid_centi)
                                                : s2_reg.humid_centi[13:0];
    assign temp_qprod  = 27'(temp_mag) * 27'(RECIP_100);
    assign humid_qprod = 27'(humid_mag) * 27'(RECIP_100);

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            s3_reg.status    <= s2_reg.status;
            s3_reg.temp_neg  <= s2_reg.temp_centi[15];
            s3_reg.temp_mag  <= temp_mag;
            s3_reg.temp_q    <= temp_qprod[RECIP_SHIFT +: 8];
            s3_reg.humid_neg <= s2_reg.humid_centi[14];
            s3_reg.humid_mag <= humid_mag;
            s3_reg.humid_q   <= humid_qprod[RECIP_SHIFT +: 7];
        end
    end

    // remainder
    logic [13:0] temp_rem_full, humid_rem_full;
    rem_stage_t  s4_reg;

    assign temp_rem_full  = s3_reg.temp_mag - times_100(s3_reg.temp_q);
    assign humid_rem_full = s3_reg.humid_mag - times_100({1'b0, s3_reg.humid_q});

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            s4_reg.status    <= s3_reg.status;
            s4_reg.temp_neg  <= s3_reg.temp_neg;
            s4_reg.temp_q    <= s3_reg.temp_q;
            s4_reg.temp_rem  <= temp_rem_full[6:0];
            s4_reg.humid_neg <= s3_reg.humid_neg;
            s4_reg.humid_q   <= s3_reg.humid_q;
            s4_reg.humid_rem <= humid_rem_full[6:0];
        end
    end

    // signed whole and micro parts
    logic [19:0] temp_frac, humid_frac;
    logic signed [8:0]  temp_whole_next;
    logic signed [20:0] temp_micro_next;
    logic signed [7:0]  humid_whole_next;
    logic signed [20:0] humid_micro_next;

    assign temp_frac  = 20'(s4_reg.temp_rem) * 20'(MICRO_SCALE);
    assign humid_frac = 20'(s4_reg.humid_rem) * 20'(MICRO_SCALE);

    always_comb
    begin
        temp_whole_next  = $signed({1'b0, s4_reg.temp_q});
        temp_micro_next  = $signed({1'b0, temp_frac});
        humid_whole_next = $signed({1'b0, s4_reg.humid_q});
        humid_micro_next = $signed({1'b0, humid_frac});
        if (s4_reg.temp_neg)
        begin
            temp_whole_next = -temp_whole_next;
            temp_micro_next = -temp_micro_next;
        end
        if (s4_reg.humid_neg)
        begin
            humid_whole_next = -humid_whole_next;
            humid_micro_next = -humid_micro_next;
        end
    end

    logic               status_reg;
    logic signed [8:0]  temp_whole_reg;
    logic signed [20:0] temp_micro_reg;
    logic signed [7:0]  humid_whole_reg;
    logic signed [20:0] humid_micro_reg;

    always_ff @(posedge clk)
    begin
        if (adv5)
        begin
            status_reg      <= s4_reg.status;
            temp_whole_reg  <= temp_whole_next;
            temp_micro_reg  <= temp_micro_next;
            humid_whole_reg <= humid_whole_next;
            humid_micro_reg <= humid_micro_next;
        end
    end

    assign out_valid   = vout_reg;
    assign status      = status_reg;
    assign temp_whole  = temp_whole_reg;
    assign temp_micro  = temp_micro_reg;
    assign humid_whole = humid_whole_reg;
    assign humid_micro = humid_micro_reg;

    // a bad checksum never touches the stored samples
    a_bad_frame_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (take0 && !crc_ok) |=> ($stable(temp_raw_reg) && $stable(humid_raw_reg)))
        else $error("stored sample changed on checksum mismatch");

    // a good temperature frame lands in the temperature register only
    a_good_temp_store: assert property (@(posedge clk) disable iff (!rst_n)
        (take0 && crc_ok && func_reg == FUNC_TEMP)
        |=> (temp_raw_reg == $past({high_reg, low_reg}) && $stable(humid_raw_reg)))
        else $error("good temperature frame not stored");

    // the status word travels with its frame
    a_status_follows: assert property (@(posedge clk) disable iff (!rst_n)
        take0 |=> (s1_reg.status == ($past(crc_ok) ? STATUS_OK : STATUS_ERR)))
        else $error("status does not match checksum result");

    // remainder after the reciprocal divide stays a digit pair
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (s4_reg.temp_rem < CENTI && s4_reg.humid_rem < CENTI))
        else $error("remainder out of range");

    // input only stalls when every stage is holding a word
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v0_reg && v1_reg && v2_reg && v3_reg && v4_reg && vout_reg && out_stall))
        else $error("input stalled with a free stage");

endmodule

/* rtl/htfc_crc8.sv */
// checksum over the two sample bytes as a flat xor network
module htfc_crc8
    import htfc_pkg::*;
(
    input  logic [15:0] data,
    output logic [7:0]  crc
);

    logic [7:0] column [16];

    genvar gi;
    generate
        for (gi = 0; gi < 16; gi++)
        begin : g_col
            localparam logic [7:0] COL = crc_column(gi);
            assign column[gi] = data[gi] ? COL : 8'd0;
        end
    endgenerate

    // crc is linear with zero init, so each set bit adds its own column
    always_comb
    begin
        crc = 8'd0;
        for (int i = 0; i < 16; i++)
        begin
            crc = crc ^ column[i];
        end
    end

endmodule

/* dv/tb_humidity_temp_frame_check_convert.sv */
// testbench for the sensor frame checksum and conversion block
module tb_humidity_temp_frame_check_convert;
    import htfc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               status;
        logic signed [8:0]  temp_whole;
        logic signed [20:0] temp_micro;
        logic signed [7:0]  humid_whole;
        logic signed [20:0] humid_micro;
    } reading_t;

    // one directed frame; chk_xor of zero means a good checksum
    typedef struct packed {
        logic               func;
        logic [7:0]         hi;
        logic [7:0]         lo;
        logic [7:0]         chk_xor;
        logic               typed;
        logic               status;
        logic signed [8:0]  tw;
        logic signed [20:0] tm;
        logic signed [7:0]  hw;
        logic signed [20:0] hm;
    } frame_row_t;

    localparam int NUM_ROWS   = 21;
    localparam int NUM_RANDOM = 1030;
    localparam int HOLD_TICKS = 60;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               func;
    logic [7:0]         sample_high;
    logic [7:0]         sample_low;
    logic [7:0]         check_byte;
    logic               out_valid;
    logic               out_stall;
    logic               status;
    logic signed [8:0]  temp_whole;
    logic signed [20:0] temp_micro;
    logic signed [7:0]  humid_whole;
    logic signed [20:0] humid_micro;

    logic [15:0] held_temp_raw;
    logic [15:0] held_humid_raw;
    reading_t    pending_readings[$];
    frame_row_t  frame_table[NUM_ROWS];
    int          errors;
    bit          cur_typed;
    reading_t    cur_want;
    bit          idle_off;
    bit          hold_rx;

    humidity_temp_frame_check_convert dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .sample_high (sample_high),
        .sample_low  (sample_low),
        .check_byte  (check_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .temp_whole  (temp_whole),
        .temp_micro  (temp_micro),
        .humid_whole (humid_whole),
        .humid_micro (humid_micro)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    // crc-8, poly 0x31, init 0, msb first, high byte then low byte
    function automatic logic [7:0] frame_crc8(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] c;
        logic [7:0] data [2];
        data[0] = hi;
        data[1] = lo;
        c = 8'd0;
        for (int b = 0; b < 2; b++)
        begin
            c = c ^ data[b];
            for (int i = 0; i < 8; i++)
            begin
                if (c[7])
                    c = {c[6:0], 1'b0} ^ CRC_POLY;
                else
                    c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // updates the held samples and returns both converted readings
    function automatic reading_t convert_frame(input logic f, input logic [7:0] hi,
                                               input logic [7:0] lo, input logic [7:0] chk);
        reading_t r;
        int       tc;
        int       hc;
        r.status = (frame_crc8(hi, lo) == chk) ? STATUS_OK : STATUS_ERR;
        if (r.status == STATUS_OK)
        begin
            if (f == FUNC_TEMP)
                held_temp_raw = {hi, lo};
            else
                held_humid_raw = {hi, lo};
        end
        tc = ((int'(held_temp_raw) * int'(T_MUL)) >>> 16) - int'(T_OFF);
        hc = ((int'(held_humid_raw) * int'(H_MUL)) >>> 16) - int'(H_OFF);
        // signed divide and modulo truncate toward zero
        r.temp_whole  = 9'(tc / int'(CENTI));
        r.temp_micro  = 21'((tc % int'(CENTI)) * int'(MICRO_SCALE));
        r.humid_whole = 8'(hc / int'(CENTI));
        r.humid_micro = 21'((hc % int'(CENTI)) * int'(MICRO_SCALE));
        return r;
    endfunction

    task automatic check_reading(input reading_t want, input reading_t got);
        if (got.status !== want.status)
        begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
        end
        if (got.temp_whole !== want.temp_whole)
        begin
            $error("temp_whole expected %0d actual %0d", want.temp_whole, got.temp_whole);
            errors++;
        end
        if (got.temp_micro !== want.temp_micro)
        begin
            $error("temp_micro expected %0d actual %0d", want.temp_micro, got.temp_micro);
            errors++;
        end
        if (got.humid_whole !== want.humid_whole)
        begin
            $error("humid_whole expected %0d actual %0d", want.humid_whole, got.humid_whole);
            errors++;
        end
        if (got.humid_micro !== want.humid_micro)
        begin
            $error("humid_micro expected %0d actual %0d", want.humid_micro, got.humid_micro);
            errors++;
        end
    endtask

    // accepted words on both sides, sampled at the rising edge
    always @(posedge clk)
    begin
        reading_t got;
        reading_t predicted;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted = convert_frame(func, sample_high, sample_low, check_byte);
                if (cur_typed)
                    pending_readings.push_back(cur_want);
                else
                    pending_readings.push_back(predicted);
            end
            if (out_valid && !out_stall)
            begin
                got = '{status, temp_whole, temp_micro, humid_whole, humid_micro};
                if (pending_readings.size() == 0)
                begin
                    $error("output word with no expected reading");
                    errors++;
                end
                else
                    check_reading(pending_readings.pop_front(), got);
            end
        end
    end

    // receiver: short random stall bursts, one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rx)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_TICKS) @(negedge clk);
                hold_rx = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!idle_off && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer_frame(input logic f, input logic [7:0] hi, input logic [7:0] lo,
                               input logic [7:0] chk, input bit typed, input reading_t want,
                               input bit allow_gap);
        if (allow_gap && !idle_off && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        func        <= f;
        sample_high <= hi;
        sample_low  <= lo;
        check_byte  <= chk;
        cur_typed    = typed;
        cur_want     = want;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    initial
    begin
        frame_row_t row;
        reading_t   want;
        logic       f;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] chk;
        int         kind;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        func           = FUNC_TEMP;
        sample_high    = 8'd0;
        sample_low     = 8'd0;
        check_byte     = 8'd0;
        held_temp_raw  = 16'd0;
        held_humid_raw = 16'd0;
        errors         = 0;
        cur_typed      = 1'b0;
        cur_want       = '0;
        idle_off       = 1'b0;
        hold_rx        = 1'b0;

        // bad frames before any store, then zero and full-scale samples
        frame_table[0]  = '{FUNC_TEMP,  8'h00, 8'h00, 8'h01, 1'b1,
                            STATUS_ERR, -9'sd46, -21'sd850000, -8'sd6, 21'sd0};
        frame_table[1]  = '{FUNC_HUMID, 8'hFF, 8'hFF, 8'h80, 1'b1,
                            STATUS_ERR, -9'sd46, -21'sd850000, -8'sd6, 21'sd0};
        frame_table[2]  = '{FUNC_TEMP,  8'h00, 8'h00, 8'h00, 1'b1,
                            STATUS_OK, -9'sd46, -21'sd850000, -8'sd6, 21'sd0};
        frame_table[3]  = '{FUNC_HUMID, 8'h00, 8'h00, 8'h00, 1'b1,
                            STATUS_OK, -9'sd46, -21'sd850000, -8'sd6, 21'sd0};
        frame_table[4]  = '{FUNC_TEMP,  8'hFF, 8'hFF, 8'h00, 1'b1,
                            STATUS_OK, 9'sd128, 21'sd860000, -8'sd6, 21'sd0};
        frame_table[5]  = '{FUNC_HUMID, 8'hFF, 8'hFF, 8'h00, 1'b1,
                            STATUS_OK, 9'sd128, 21'sd860000, 8'sd118, 21'sd990000};
        // mismatch keeps both held samples
        frame_table[6]  = '{FUNC_TEMP,  8'h00, 8'h00, 8'hFF, 1'b1,
                            STATUS_ERR, 9'sd128, 21'sd860000, 8'sd118, 21'sd990000};
        frame_table[7]  = '{FUNC_HUMID, 8'h12, 8'h34, 8'h10, 1'b1,
                            STATUS_ERR, 9'sd128, 21'sd860000, 8'sd118, 21'sd990000};
        // just below zero: whole part zero with a negative fraction; at zero both parts are zero
        frame_table[8]  = '{FUNC_TEMP,  8'h44, 8'h3E, 8'h00, 1'b0, 1'b0,
                            9'sd0, 21'sd0, 8'sd0, 21'sd0};
        frame_table[9]  = '{FUNC_TEMP,  8'h44, 8'h42, 8'h00, 1'b0, 1'b0,
                            9'sd0, 21'sd0, 8'sd0, 21'sd0};
        frame_table[10] = '{FUNC_HUMID, 8'h0C, 8'h49, 8'h00, 1'b0, 1'b0,
                            9'sd0, 21'sd0, 8'sd0, 21'sd0};
        frame_table[11] = '{FUNC_HUMID, 8'h0C, 8'h4A, 8'h00, 1'b0, 1'b0,
                            9'sd0, 21'sd0, 8'sd0, 21'sd0};
        frame_table[12] = '{FUNC_TEMP,  8'h80, 8'h00, 8'h00, 1'b0, 1'b0,
                            9'sd0, 21'sd0, 8'sd0, 21'sd0};
        frame_table[13] = '{FUNC_HUMID, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0,
                            9'sd0, 21'sd0, 8'sd0, 21'sd0};
        frame_table[14] = '{FUNC_TEMP,  8'hFF, 8'h00, 8'h00, 1'b0, 1'b0,
                            9'sd0, 21'sd0, 8'sd0, 21'sd0};
        frame_table[15] = '{FUNC_HUMID, 8'hAA, 8'h55, 8'h00, 1'b0, 1'b0,
                            9'sd0, 21'sd0, 8'sd0, 21'sd0};
        frame_table[16] = '{FUNC_TEMP,  8'h55, 8'hAA, 8'h02, 1'b0, 1'b0,
                            9'sd0, 21'sd0, 8'sd0, 21'sd0};
        frame_table[17] = '{FUNC_HUMID, 8'h01, 8'h01, 8'h00, 1'b0, 1'b0,
                            9'sd0, 21'sd0, 8'sd0, 21'sd0};
        frame_table[18] = '{FUNC_TEMP,  8'h66, 8'h66, 8'h00, 1'b0, 1'b0,
                            9'sd0, 21'sd0, 8'sd0, 21'sd0};
        frame_table[19] = '{FUNC_HUMID, 8'h7F, 8'hFF, 8'h00, 1'b0, 1'b0,
                            9'sd0, 21'sd0, 8'sd0, 21'sd0};
        frame_table[20] = '{FUNC_TEMP,  8'h12, 8'h34, 8'h40, 1'b0, 1'b0,
                            9'sd0, 21'sd0, 8'sd0, 21'sd0};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row  = frame_table[r];
            want = '{row.status, row.tw, row.tm, row.hw, row.hm};
            offer_frame(row.func, row.hi, row.lo, frame_crc8(row.hi, row.lo) ^ row.chk_xor,
                        row.typed, want, 1'b1);
        end

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            idle_off = (i >= 450 && i < 520) || i >= 880;
            // long receiver hold-off while words keep coming
            if (i == 250)
                hold_rx = 1'b1;
            // let the pipeline drain completely once
            if (i == 600)
            begin
                in_valid <= 1'b0;
                wait (pending_readings.size() == 0);
                @(negedge clk);
            end
            kind = $urandom_range(0, 9);
            f    = 1'($urandom_range(0, 1));
            hi   = 8'($urandom_range(0, 255));
            lo   = 8'($urandom_range(0, 255));
            if (kind == 9)
            begin
                hi = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
                lo = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
            end
            chk = frame_crc8(hi, lo);
            if (kind == 7 || kind == 8)
                chk = chk ^ 8'($urandom_range(1, 255));
            offer_frame(f, hi, lo, chk, 1'b0, '0, !(i >= 250 && i < 300));
        end
        in_valid <= 1'b0;

        wait (pending_readings.size() == 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
